>>> hdl/rcc_pkg.sv
// Shared widths, codes and defaults for the range chmax coverage counter.
package rcc_pkg;

    localparam int FUNC_W        = 1;
    localparam int SLOT_W        = 11;
    localparam int HEIGHT_W      = 30;
    localparam int COUNT_W       = 11;
    localparam int TOTAL_W       = 40;
    localparam int S_TDATA_W     = 56;
    localparam int M_TDATA_W     = 56;
    localparam int POSITIONS_DEF = 1024;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 1'b0,
        FUNC_CLEAR  = 1'b1
    } func_t;

endpackage

>>> hdl/range_chmax_count_covered_core.sv
// Segment-tree range chmax engine with coverage count and saturating total.
// Clear rewrites the root and an empty span skips the walk; an insert walks the count nodes
// and leaves, raising covered nodes, and an output stall holds the result. One transaction at
// a time, ready again in the cycle the result appears; a walk visits about 4*log2(POSITIONS)
// nodes. Reset: the init state writes the root as uniform height 0; the root rewrite is also
// how a clear works, since nodes below a uniform node are never read before being rewritten.
module range_chmax_count_covered_core
    import rcc_pkg::*;
#(
    parameter int POSITIONS = POSITIONS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // left[10:0], right[21:11], height[51:22], zero pad
    input  logic [FUNC_W-1:0]    s_tuser,   // func[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // covered_count[10:0], case_total[50:11], zero pad
);

    localparam int SW    = $clog2(POSITIONS + 1);
    localparam int IW    = $clog2(POSITIONS) + 1;
    localparam int NODES = 1 << IW;
    localparam int STK_D = $clog2(POSITIONS) + 1;
    localparam int SPI_W = $clog2(STK_D);
    localparam int SP_W  = $clog2(STK_D + 1);
    localparam int CMP_W = ((SW > SLOT_W) ? SW : SLOT_W) + 1;
    localparam int MEM_W = HEIGHT_W + 1;
    localparam int M_PAD = M_TDATA_W - COUNT_W - TOTAL_W;

    typedef struct packed {
        logic [IW-1:0] idx;
        logic [SW-1:0] lo;
        logic [SW-1:0] hi;
        logic [SW-1:0] a;
        logic [SW-1:0] b;
    } frame_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_RD,
        ST_EVAL,
        ST_RAISE,
        ST_ROFF,
        ST_POP,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    frame_t               cur_reg, cur_next;
    frame_t               pend_reg, pend_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [HEIGHT_W-1:0]  h_reg, h_next;
    logic [HEIGHT_W-1:0]  g_reg, g_next;
    logic [SW-1:0]        cnt_reg, cnt_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [SP_W-1:0]      sp_reg, sp_next;
    logic [IW-1:0]        off_idx_reg, off_idx_next;
    logic [MEM_W-1:0]     off_data_reg, off_data_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;
    logic [TOTAL_W-1:0]   out_total_reg, out_total_next;

    // node memory: {uniform, height}
    logic [MEM_W-1:0]     node_mem [NODES];
    logic [MEM_W-1:0]     rd_data;
    logic                 mem_we;
    logic [IW-1:0]        mem_waddr;
    logic [MEM_W-1:0]     mem_wdata;

    // pending right siblings of the count walk
    frame_t               stk_mem [STK_D];
    logic                 push;
    frame_t               push_frame;
    logic [SP_W-1:0]      sp_dec;

    logic [SLOT_W-1:0]    in_left;
    logic [SLOT_W-1:0]    in_right;
    logic [HEIGHT_W-1:0]  in_height;
    logic [CMP_W-1:0]     left_ext, right_ext, left_c, right_c, right_m1;
    logic                 span_ok;

    logic [SW:0]          mid_sum;
    logic [SW-1:0]        mid, mid_p1;
    logic [IW-1:0]        idx_l, idx_r;
    logic [SW-1:0]        span_len;
    logic                 rd_uni;
    logic [HEIGHT_W-1:0]  rd_ht;
    logic [TOTAL_W:0]     sum_total;
    logic [TOTAL_W-1:0]   total_sat;
    logic                 exact, left_exact;

    assign in_left   = s_tdata[SLOT_W-1:0];
    assign in_right  = s_tdata[2*SLOT_W-1:SLOT_W];
    assign in_height = s_tdata[2*SLOT_W+HEIGHT_W-1:2*SLOT_W];

    assign left_ext  = CMP_W'(in_left);
    assign right_ext = CMP_W'(in_right);
    assign left_c    = (left_ext == '0) ? CMP_W'(1) : left_ext;
    assign right_c   = (right_ext > CMP_W'(POSITIONS + 1)) ? CMP_W'(POSITIONS + 1) : right_ext;
    assign right_m1  = right_c - CMP_W'(1);
    assign span_ok   = left_c < right_c;

    assign mid_sum    = {1'b0, cur_reg.lo} + {1'b0, cur_reg.hi};
    assign mid        = mid_sum[SW:1];
    assign mid_p1     = mid + SW'(1);
    assign idx_l      = {cur_reg.idx[IW-2:0], 1'b0};
    assign idx_r      = {cur_reg.idx[IW-2:0], 1'b1};
    assign span_len   = cur_reg.b - cur_reg.a + SW'(1);
    assign rd_uni     = rd_data[HEIGHT_W];
    assign rd_ht      = rd_data[HEIGHT_W-1:0];
    assign exact      = (cur_reg.a == cur_reg.lo) && (cur_reg.b == cur_reg.hi);
    assign left_exact = (cur_reg.a == cur_reg.lo);

    assign sum_total = {1'b0, total_reg} + (TOTAL_W + 1)'(cnt_reg);
    assign total_sat = sum_total[TOTAL_W] ? TOTAL_MAX : sum_total[TOTAL_W-1:0];

    assign sp_dec = sp_reg - SP_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {M_PAD'(0), out_total_reg, out_count_reg};

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        h_next          = h_reg;
        g_next          = g_reg;
        cnt_next        = cnt_reg;
        total_next      = total_reg;
        sp_next         = sp_reg;
        off_idx_next    = off_idx_reg;
        off_data_next   = off_data_reg;
        out_valid_next  = out_valid_reg;
        out_count_next  = out_count_reg;
        out_total_next  = out_total_reg;
        mem_we          = 1'b0;
        mem_waddr       = cur_reg.idx;
        mem_wdata       = {1'b0, g_reg};
        push            = 1'b0;
        push_frame      = '{idx: idx_r, lo: mid_p1, hi: cur_reg.hi, a: mid_p1, b: cur_reg.b};

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = IW'(1);
                mem_wdata  = {1'b1, {HEIGHT_W{1'b0}}};
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    h_next          = in_height;
                    cnt_next        = '0;
                    sp_next         = '0;
                    pend_valid_next = 1'b0;
                    if (s_tuser == FUNC_CLEAR)
                    begin
                        total_next = '0;
                        state_next = ST_CLR;
                    end
                    else if (span_ok)
                    begin
                        cur_next   = '{idx: IW'(1), lo: SW'(1), hi: SW'(POSITIONS),
                                       a: left_c[SW-1:0], b: right_m1[SW-1:0]};
                        state_next = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CLR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = IW'(1);
                mem_wdata  = {1'b1, {HEIGHT_W{1'b0}}};
                state_next = ST_DONE;
            end
            ST_RD:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (rd_uni)
                begin
                    if (h_reg >= rd_ht)
                    begin
                        cnt_next   = cnt_reg + span_len;
                        g_next     = rd_ht;
                        state_next = ST_RAISE;
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    state_next = ST_RD;
                    if (cur_reg.b <= mid)
                    begin
                        cur_next = '{idx: idx_l, lo: cur_reg.lo, hi: mid,
                                     a: cur_reg.a, b: cur_reg.b};
                    end
                    else if (cur_reg.a > mid)
                    begin
                        cur_next = '{idx: idx_r, lo: mid_p1, hi: cur_reg.hi,
                                     a: cur_reg.a, b: cur_reg.b};
                    end
                    else
                    begin
                        push     = 1'b1;
                        sp_next  = sp_reg + SP_W'(1);
                        cur_next = '{idx: idx_l, lo: cur_reg.lo, hi: mid,
                                     a: cur_reg.a, b: mid};
                    end
                end
            end
            ST_RAISE:
            begin
                // every node on this walk is uniform at height g, with g <= h
                mem_we    = 1'b1;
                mem_waddr = cur_reg.idx;
                if (exact)
                begin
                    mem_wdata = {1'b1, h_reg};
                    if (pend_valid_reg)
                    begin
                        cur_next        = pend_reg;
                        pend_valid_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    mem_wdata = {1'b0, g_reg};
                    if (cur_reg.b <= mid)
                    begin
                        off_idx_next  = idx_r;
                        off_data_next = {1'b1, g_reg};
                        cur_next      = '{idx: idx_l, lo: cur_reg.lo, hi: mid,
                                          a: cur_reg.a, b: cur_reg.b};
                        state_next    = ST_ROFF;
                    end
                    else if (cur_reg.a > mid)
                    begin
                        off_idx_next  = idx_l;
                        off_data_next = {1'b1, g_reg};
                        cur_next      = '{idx: idx_r, lo: mid_p1, hi: cur_reg.hi,
                                          a: cur_reg.a, b: cur_reg.b};
                        state_next    = ST_ROFF;
                    end
                    else if (left_exact)
                    begin
                        // left half fully covered
                        off_idx_next  = idx_l;
                        off_data_next = {1'b1, h_reg};
                        cur_next      = '{idx: idx_r, lo: mid_p1, hi: cur_reg.hi,
                                          a: mid_p1, b: cur_reg.b};
                        state_next    = ST_ROFF;
                    end
                    else if (cur_reg.b == cur_reg.hi)
                    begin
                        // right half fully covered
                        off_idx_next  = idx_r;
                        off_data_next = {1'b1, h_reg};
                        cur_next      = '{idx: idx_l, lo: cur_reg.lo, hi: mid,
                                          a: cur_reg.a, b: mid};
                        state_next    = ST_ROFF;
                    end
                    else
                    begin
                        // both ends interior: only happens once per walk
                        pend_valid_next = 1'b1;
                        pend_next       = '{idx: idx_r, lo: mid_p1, hi: cur_reg.hi,
                                            a: mid_p1, b: cur_reg.b};
                        cur_next        = '{idx: idx_l, lo: cur_reg.lo, hi: mid,
                                            a: cur_reg.a, b: mid};
                    end
                end
            end
            ST_ROFF:
            begin
                mem_we     = 1'b1;
                mem_waddr  = off_idx_reg;
                mem_wdata  = off_data_reg;
                state_next = ST_RAISE;
            end
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cur_next   = stk_mem[sp_dec[SPI_W-1:0]];
                    sp_next    = sp_dec;
                    state_next = ST_RD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = COUNT_W'(cnt_reg);
                    out_total_next = total_sat;
                    total_next     = total_sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cur_reg        <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            h_reg          <= '0;
            g_reg          <= '0;
            cnt_reg        <= '0;
            total_reg      <= '0;
            sp_reg         <= '0;
            off_idx_reg    <= '0;
            off_data_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_count_reg  <= '0;
            out_total_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            h_reg          <= h_next;
            g_reg          <= g_next;
            cnt_reg        <= cnt_next;
            total_reg      <= total_next;
            sp_reg         <= sp_next;
            off_idx_reg    <= off_idx_next;
            off_data_reg   <= off_data_next;
            out_valid_reg  <= out_valid_next;
            out_count_reg  <= out_count_next;
            out_total_reg  <= out_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            node_mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= node_mem[cur_reg.idx];
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_mem[sp_reg[SPI_W-1:0]] <= push_frame;
        end
    end

endmodule

>>> hdl/rcc_checker.sv
// Port-level checks for the range chmax coverage counter, bound to the core module.
module rcc_checker
    import rcc_pkg::*;
#(
    parameter int POSITIONS = POSITIONS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: ready drops right after an accepted transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after accept");

    // no result appears out of an idle cycle with nothing accepted
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && !s_tvalid |=> !$rose(m_tvalid))
        else $error("result without accepted item");

    // the count never exceeds the number of slots
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[COUNT_W-1:0]) <= 32'(POSITIONS)))
        else $error("covered count out of range");

endmodule

bind range_chmax_count_covered_core rcc_checker #(.POSITIONS(POSITIONS)) u_rcc_checker (.*);
